### design/emq_pkg.sv
package emq_pkg;

    localparam int MAX_SLOTS_DEFAULT = 16;
    localparam int STAT_BITS_DEFAULT = 32;

    localparam int KIND_W          = 3;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 3;
    localparam int SEL_W           = 3;
    localparam int MSG_ID_W        = 16;
    localparam int CLASS_W         = 2;
    localparam int SIZE_W          = 8;
    localparam int WORD_W          = 32;
    localparam int SLOT_W          = MSG_ID_W + CLASS_W + SIZE_W + WORD_W;
    localparam int FILL_W          = 5;
    localparam int STAT_OUT_W      = 32;
    localparam int IN_DATA_W       = 64;
    localparam int OUT_DATA_W      = 128;
    localparam int NUM_EVENT_STATS = 6;
    localparam int NUM_STATS       = 7;
    localparam int CAP_RAW_W       = 5;

    localparam logic [KIND_W-1:0] KIND_FIFO8    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIFO16   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SINGLE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOSSY    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COALESCE = 3'd4;

    localparam logic [CMD_W-1:0] CMD_PUSH      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_STAT = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_EXTERNAL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_VIOLATION = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_RETAIN    = 3'd5;

    localparam logic [SEL_W-1:0] STAT_POSTED    = 3'd0;
    localparam logic [SEL_W-1:0] STAT_REJECTED  = 3'd1;
    localparam logic [SEL_W-1:0] STAT_DROPPED   = 3'd2;
    localparam logic [SEL_W-1:0] STAT_REPLACED  = 3'd3;
    localparam logic [SEL_W-1:0] STAT_COALESCED = 3'd4;
    localparam logic [SEL_W-1:0] STAT_POPPED    = 3'd5;
    localparam logic [SEL_W-1:0] STAT_WATERMARK = 3'd6;
    localparam logic [SEL_W-1:0] STAT_UNKNOWN   = 3'd7;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ONE,
        CNT_ZERO
    } cnt_op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CMD_W-1:0]  command;
        logic              msg_valid;
        logic              retain_ok;
        logic              needs_retain;
        logic              has_payload;
        logic              count_zero;
        logic              count_full;
        logic              id_match;
    } dp_status_t;

    typedef struct packed {
        logic                       load_in;
        logic                       exec;
        logic                       cfg_wr;
        logic                       clear;
        logic                       slot_wr;
        logic                       tail_adv;
        logic                       head_adv;
        cnt_op_t                    cnt_op;
        logic [NUM_EVENT_STATS-1:0] bump;
        logic                       watermark;
        logic                       rel_out;
        logic                       pop_out;
        logic                       stat_read;
        logic [STATUS_W-1:0]        status;
    } dp_cmd_t;

    function automatic logic [CAP_RAW_W-1:0] kind_capacity(input logic [KIND_W-1:0] kind);
        logic [CAP_RAW_W-1:0] cap;
        unique case (kind)
            KIND_FIFO8:    cap = 5'd8;
            KIND_FIFO16:   cap = 5'd16;
            KIND_SINGLE:   cap = 5'd1;
            KIND_LOSSY:    cap = 5'd8;
            KIND_COALESCE: cap = 5'd1;
            default:       cap = 5'd0;
        endcase
        return cap;
    endfunction

endpackage

### design/emq_ram.sv
module emq_ram #(
    parameter int WIDTH = emq_pkg::SLOT_W,
    parameter int DEPTH = emq_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### design/emq_ctrl.sv
module emq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  emq_pkg::dp_status_t st,
    output emq_pkg::dp_cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_exec;
    logic   retain_fail;

    assign cfg_ready   = (state_reg == S_IDLE);
    assign s_tready    = (state_reg == S_IDLE) && !cfg_valid;
    assign m_tvalid    = out_valid_reg;
    assign can_exec    = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);
    assign retain_fail = st.needs_retain && !st.retain_ok;

    always_comb begin
        cmd         = '0;
        cmd.cnt_op  = emq_pkg::CNT_HOLD;
        cmd.status  = emq_pkg::STATUS_OK;
        cmd.load_in = s_tvalid && s_tready;
        cmd.cfg_wr  = cfg_valid && cfg_ready;
        cmd.exec    = can_exec;

        unique case (st.command)
            emq_pkg::CMD_PUSH: begin
                if (!st.msg_valid) begin
                    cmd.status                      = emq_pkg::STATUS_INVALID;
                    cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                end else begin
                    unique case (st.kind) inside
                        emq_pkg::KIND_FIFO8, emq_pkg::KIND_FIFO16: begin
                            if (st.count_full) begin
                                cmd.status                       = emq_pkg::STATUS_FULL;
                                cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                            end else if (retain_fail) begin
                                cmd.status                       = emq_pkg::STATUS_RETAIN;
                                cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                            end else begin
                                cmd.slot_wr                    = 1'b1;
                                cmd.tail_adv                   = 1'b1;
                                cmd.cnt_op                     = emq_pkg::CNT_INC;
                                cmd.bump[emq_pkg::STAT_POSTED] = 1'b1;
                                cmd.watermark                  = 1'b1;
                            end
                        end
                        emq_pkg::KIND_SINGLE: begin
                            if (retain_fail) begin
                                cmd.status                       = emq_pkg::STATUS_RETAIN;
                                cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                            end else begin
                                cmd.slot_wr   = 1'b1;
                                cmd.watermark = 1'b1;
                                if (st.count_zero) begin
                                    cmd.cnt_op                     = emq_pkg::CNT_ONE;
                                    cmd.bump[emq_pkg::STAT_POSTED] = 1'b1;
                                end else begin
                                    cmd.rel_out                      = 1'b1;
                                    cmd.bump[emq_pkg::STAT_REPLACED] = 1'b1;
                                end
                            end
                        end
                        emq_pkg::KIND_LOSSY: begin
                            if (retain_fail) begin
                                cmd.status                       = emq_pkg::STATUS_RETAIN;
                                cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                            end else begin
                                cmd.slot_wr                    = 1'b1;
                                cmd.tail_adv                   = 1'b1;
                                cmd.bump[emq_pkg::STAT_POSTED] = 1'b1;
                                cmd.watermark                  = 1'b1;
                                if (st.count_full) begin
                                    cmd.rel_out                     = 1'b1;
                                    cmd.head_adv                    = 1'b1;
                                    cmd.bump[emq_pkg::STAT_DROPPED] = 1'b1;
                                end else begin
                                    cmd.cnt_op = emq_pkg::CNT_INC;
                                end
                            end
                        end
                        emq_pkg::KIND_COALESCE: begin
                            if (st.has_payload) begin
                                cmd.status                       = emq_pkg::STATUS_VIOLATION;
                                cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                            end else if (st.count_zero) begin
                                cmd.slot_wr                    = 1'b1;
                                cmd.cnt_op                     = emq_pkg::CNT_ONE;
                                cmd.bump[emq_pkg::STAT_POSTED] = 1'b1;
                                cmd.watermark                  = 1'b1;
                            end else if (!st.id_match) begin
                                cmd.status                       = emq_pkg::STATUS_VIOLATION;
                                cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                            end else begin
                                cmd.bump[emq_pkg::STAT_COALESCED] = 1'b1;
                            end
                        end
                        default: begin
                            cmd.status                       = emq_pkg::STATUS_VIOLATION;
                            cmd.bump[emq_pkg::STAT_REJECTED] = 1'b1;
                        end
                    endcase
                end
            end
            emq_pkg::CMD_POP: begin
                if (st.count_zero) begin
                    cmd.status = emq_pkg::STATUS_EMPTY;
                end else begin
                    unique case (st.kind) inside
                        emq_pkg::KIND_FIFO8, emq_pkg::KIND_FIFO16, emq_pkg::KIND_LOSSY: begin
                            cmd.pop_out                    = 1'b1;
                            cmd.head_adv                   = 1'b1;
                            cmd.cnt_op                     = emq_pkg::CNT_DEC;
                            cmd.bump[emq_pkg::STAT_POPPED] = 1'b1;
                        end
                        emq_pkg::KIND_SINGLE, emq_pkg::KIND_COALESCE: begin
                            cmd.pop_out                    = 1'b1;
                            cmd.cnt_op                     = emq_pkg::CNT_ZERO;
                            cmd.bump[emq_pkg::STAT_POPPED] = 1'b1;
                        end
                        default: begin
                            cmd.status = emq_pkg::STATUS_VIOLATION;
                        end
                    endcase
                end
            end
            emq_pkg::CMD_CLEAR: begin
                cmd.clear = 1'b1;
            end
            emq_pkg::CMD_READ_STAT: begin
                cmd.stat_read = 1'b1;
            end
            default: begin
                cmd.status = emq_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_exec) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/emq_datapath.sv
module emq_datapath #(
    parameter int MAX_SLOTS = emq_pkg::MAX_SLOTS_DEFAULT,
    parameter int STAT_BITS = emq_pkg::STAT_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [emq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [emq_pkg::CMD_W-1:0]         s_tuser,
    input  logic [emq_pkg::KIND_W-1:0]        cfg_data,
    input  emq_pkg::dp_cmd_t                  cmd,
    output emq_pkg::dp_status_t               st,
    output logic [emq_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [emq_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CAP_W = $clog2(MAX_SLOTS + 1);

    logic [emq_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [IDX_W-1:0]           tail_reg, tail_next;
    logic [CAP_W-1:0]           count_reg, count_next;
    logic [STAT_BITS-1:0]       stat_reg [emq_pkg::NUM_STATS];
    logic [STAT_BITS-1:0]       stat_next [emq_pkg::NUM_STATS];

    logic [emq_pkg::CMD_W-1:0]      command_reg;
    logic [emq_pkg::MSG_ID_W-1:0]   msg_id_reg;
    logic [emq_pkg::CLASS_W-1:0]    class_reg;
    logic [emq_pkg::SIZE_W-1:0]     size_reg;
    logic [emq_pkg::WORD_W-1:0]     word_reg;
    logic                           msg_valid_reg;
    logic                           retain_ok_reg;
    logic [emq_pkg::SEL_W-1:0]      sel_reg;

    logic [emq_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [emq_pkg::STATUS_W-1:0]   out_status_reg;

    logic [emq_pkg::CAP_RAW_W-1:0] cap_raw;
    logic [CAP_W-1:0]              cap;
    logic [IDX_W-1:0]              idx_mask;
    logic                          slot_fixed;
    logic                          clear_all;

    logic [emq_pkg::SLOT_W-1:0]     rd_data;
    logic [emq_pkg::SLOT_W-1:0]     wr_data;
    logic [IDX_W-1:0]               rd_addr;
    logic [IDX_W-1:0]               wr_addr;
    logic [emq_pkg::MSG_ID_W-1:0]   rd_msg_id;
    logic [emq_pkg::CLASS_W-1:0]    rd_class;
    logic [emq_pkg::SIZE_W-1:0]     rd_size;
    logic [emq_pkg::WORD_W-1:0]     rd_word;

    logic [emq_pkg::MSG_ID_W-1:0]   pop_msg_id;
    logic [emq_pkg::CLASS_W-1:0]    pop_class;
    logic [emq_pkg::SIZE_W-1:0]     pop_size;
    logic [emq_pkg::WORD_W-1:0]     pop_word;
    logic [emq_pkg::WORD_W-1:0]     rel_word;
    logic [emq_pkg::STAT_OUT_W-1:0] stat_value;

    always_comb begin
        cap_raw = emq_pkg::kind_capacity(kind_reg);
        if (int'(cap_raw) > MAX_SLOTS) begin
            cap = CAP_W'(MAX_SLOTS);
        end else begin
            cap = CAP_W'(cap_raw);
        end
        idx_mask = IDX_W'(cap - CAP_W'(1));
    end

    assign slot_fixed = (kind_reg == emq_pkg::KIND_SINGLE) || (kind_reg == emq_pkg::KIND_COALESCE);
    assign rd_addr    = slot_fixed ? '0 : head_reg;
    assign wr_addr    = slot_fixed ? '0 : tail_reg;
    assign wr_data    = {word_reg, size_reg, class_reg, msg_id_reg};

    emq_ram #(
        .WIDTH(emq_pkg::SLOT_W),
        .DEPTH(MAX_SLOTS)
    ) u_slot_ram (
        .aclk   (aclk),
        .wr_en  (cmd.exec && cmd.slot_wr),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.load_in),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_msg_id = rd_data[15:0];
    assign rd_class  = rd_data[17:16];
    assign rd_size   = rd_data[25:18];
    assign rd_word   = rd_data[57:26];

    always_comb begin
        st.kind         = kind_reg;
        st.command      = command_reg;
        st.msg_valid    = msg_valid_reg;
        st.retain_ok    = retain_ok_reg;
        st.needs_retain = (class_reg == emq_pkg::CLASS_EXTERNAL) && (size_reg != '0);
        st.has_payload  = (class_reg != '0) || (size_reg != '0);
        st.count_zero   = (count_reg == '0);
        st.count_full   = (count_reg >= cap);
        st.id_match     = (rd_msg_id == msg_id_reg);
    end

    assign clear_all = cmd.cfg_wr || (cmd.exec && cmd.clear);

    always_comb begin
        kind_next  = cmd.cfg_wr ? cfg_data : kind_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (clear_all) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (cmd.exec) begin
            if (cmd.head_adv) begin
                head_next = (head_reg + IDX_W'(1)) & idx_mask;
            end
            if (cmd.tail_adv) begin
                tail_next = (tail_reg + IDX_W'(1)) & idx_mask;
            end
            case (cmd.cnt_op)
                emq_pkg::CNT_INC:  count_next = count_reg + CAP_W'(1);
                emq_pkg::CNT_DEC:  count_next = count_reg - CAP_W'(1);
                emq_pkg::CNT_ONE:  count_next = CAP_W'(1);
                emq_pkg::CNT_ZERO: count_next = '0;
                default:           count_next = count_reg;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < emq_pkg::NUM_STATS; i++) begin
            stat_next[i] = stat_reg[i];
        end
        if (clear_all) begin
            for (int i = 0; i < emq_pkg::NUM_STATS; i++) begin
                stat_next[i] = '0;
            end
        end else if (cmd.exec) begin
            for (int i = 0; i < emq_pkg::NUM_EVENT_STATS; i++) begin
                if (cmd.bump[i]) begin
                    stat_next[i] = stat_reg[i] + STAT_BITS'(1);
                end
            end
            if (cmd.watermark && (STAT_BITS'(count_next) > stat_reg[emq_pkg::STAT_WATERMARK])) begin
                stat_next[emq_pkg::STAT_WATERMARK] = STAT_BITS'(count_next);
            end
        end
    end

    always_comb begin
        pop_msg_id = cmd.pop_out ? rd_msg_id : '0;
        pop_class  = cmd.pop_out ? rd_class : '0;
        pop_size   = cmd.pop_out ? rd_size : '0;
        pop_word   = cmd.pop_out ? rd_word : '0;
        rel_word   = cmd.rel_out ? rd_word : '0;
        stat_value = '0;
        if (cmd.stat_read && (sel_reg != emq_pkg::STAT_UNKNOWN)) begin
            stat_value = emq_pkg::STAT_OUT_W'(stat_reg[sel_reg]);
        end
        out_data_next = {rel_word, cmd.rel_out, stat_value,
                         emq_pkg::FILL_W'(count_next),
                         pop_word, pop_size, pop_class, pop_msg_id};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= emq_pkg::KIND_FIFO8;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < emq_pkg::NUM_STATS; i++) begin
                stat_reg[i] <= '0;
            end
        end else begin
            kind_reg  <= kind_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            for (int i = 0; i < emq_pkg::NUM_STATS; i++) begin
                stat_reg[i] <= stat_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            command_reg   <= s_tuser;
            msg_id_reg    <= s_tdata[15:0];
            class_reg     <= s_tdata[17:16];
            size_reg      <= s_tdata[25:18];
            word_reg      <= s_tdata[57:26];
            msg_valid_reg <= s_tdata[58];
            retain_ok_reg <= s_tdata[59];
            sel_reg       <= s_tdata[62:60];
        end
        if (cmd.exec) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= cmd.status;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_status_reg;

endmodule

### design/event_mailbox_queue.sv
// Message mailbox that behaves as an 8-deep FIFO, a 16-deep FIFO, a single overwriting slot,
// an 8-deep ring that drops its oldest entry, or a coalescing event flag, chosen by the kind
// register; writing the kind clears pointers, fill count and statistics. Each command beat
// on the slave side yields exactly one result beat on the master side. The beat is accepted
// while the slot memory read is launched; the command then completes once that registered
// read has returned and the output register is free. The result is held in an output
// register, so the next command is accepted while an earlier result still waits.
// Dropped or replaced entries report their payload word for release; the slot memory needs
// no clearing after reset.
module event_mailbox_queue #(
    parameter int MAX_SLOTS = emq_pkg::MAX_SLOTS_DEFAULT,
    parameter int STAT_BITS = emq_pkg::STAT_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [emq_pkg::KIND_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: event identifier, storage class, payload length, payload word,
    // message valid, retain ok, statistic select, zero pad.
    input  logic [emq_pkg::IN_DATA_W-1:0]     s_tdata,
    // Command.
    input  logic [emq_pkg::CMD_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: popped event identifier, popped storage class, popped payload
    // length, popped payload word, fill count, statistic value, release valid, release word.
    output logic [emq_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Status.
    output logic [emq_pkg::STATUS_W-1:0]      m_tuser
);

    emq_pkg::dp_status_t dp_status;
    emq_pkg::dp_cmd_t    dp_cmd;

    emq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (dp_status),
        .cmd      (dp_cmd)
    );

    emq_datapath #(
        .MAX_SLOTS(MAX_SLOTS),
        .STAT_BITS(STAT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cfg_data(cfg_data),
        .cmd     (dp_cmd),
        .st      (dp_status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
